// ===== sv/efvf_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the egomotion flow filter.
// Used by every module of the block; depends on nothing.
package efvf_pkg;

  localparam int COORD_BITS    = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int DATA_W        = 36;   // CORDIC datapath width, holds focus-relative offsets
  localparam int ANGLE_W       = 16;   // Q3.12 angle accumulator
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = 2;
  localparam int DIV_STEPS     = 48;
  localparam int DIV_CNT_W     = 6;

  localparam logic signed [ANGLE_W-1:0] HALF_PI = 16'sd6434;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ODOM_X       = 3'd0,
    REG_ODOM_Y       = 3'd1,
    REG_ODOM_Z       = 3'd2,
    REG_WIDTH_PX     = 3'd3,
    REG_HEIGHT_PX    = 3'd4,
    REG_ANGLE_THRESH = 3'd5,
    REG_SAMPLE_SHIFT = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                         present;
    logic        [COORD_BITS-1:0] pos_x;
    logic        [COORD_BITS-1:0] pos_y;
    logic signed [15:0]           flow_u;
    logic signed [15:0]           flow_v;
  } in_item_t;

  typedef struct packed {
    logic                         keep;
    logic        [COORD_BITS-1:0] out_x;
    logic        [COORD_BITS-1:0] out_y;
    logic signed [15:0]           out_u;
    logic signed [15:0]           out_v;
  } out_item_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic                         active;
    logic        [COORD_BITS-1:0] pos_x;
    logic        [COORD_BITS-1:0] pos_y;
    logic signed [15:0]           flow_u;
    logic signed [15:0]           flow_v;
    logic signed [DATA_W-1:0]     dx;
    logic signed [DATA_W-1:0]     dy;
  } work_item_t;

  typedef struct packed {
    logic                         active;
    logic        [COORD_BITS-1:0] pos_x;
    logic        [COORD_BITS-1:0] pos_y;
    logic signed [15:0]           flow_u;
    logic signed [15:0]           flow_v;
  } pass_t;

  // atan(2^-i) in Q3.12, rounded to nearest
  function automatic logic signed [ANGLE_W-1:0] atan_q12(input int i);
    logic signed [ANGLE_W-1:0] a;
    case (i)
      0:  a = 16'sd3217;
      1:  a = 16'sd1899;
      2:  a = 16'sd1003;
      3:  a = 16'sd509;
      4:  a = 16'sd256;
      5:  a = 16'sd128;
      6:  a = 16'sd64;
      7:  a = 16'sd32;
      8:  a = 16'sd16;
      9:  a = 16'sd8;
      10: a = 16'sd4;
      11: a = 16'sd2;
      12: a = 16'sd1;
      default: a = 16'sd0;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/efvf_div.sv =====
// Sequential signed divider for one focus component: (num * 2^16) / den, saturated.
// Restoring division, one quotient bit per cycle. Uses efvf_pkg.
module efvf_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  num,
  input  logic signed [31:0]  den,
  output logic                busy,
  output logic signed [31:0]  quo
);

  logic [47:0]                       dvd;
  logic [31:0]                       rem;
  logic [31:0]                       dmag;
  logic [efvf_pkg::DIV_CNT_W-1:0]    cnt;
  logic                              neg;

  logic [31:0] nmag_in;
  logic [31:0] dmag_in;
  logic [32:0] trial;
  logic        take;
  logic [31:0] rem_next;
  logic [47:0] dvd_next;

  assign nmag_in = num[31] ? 32'(-num) : 32'(num);
  assign dmag_in = den[31] ? 32'(-den) : 32'(den);

  always_comb begin
    trial    = {rem, dvd[47]};
    take     = trial >= {1'b0, dmag};
    rem_next = take ? 32'(trial - {1'b0, dmag}) : trial[31:0];
    dvd_next = {dvd[46:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      quo  <= '0;
    end else if (start) begin
      if (den == 32'sd0) begin
        busy <= 1'b0;
        if (num > 32'sd0)      quo <= 32'sh7FFFFFFF;
        else if (num < 32'sd0) quo <= 32'sh80000000;
        else                   quo <= '0;
      end else begin
        busy <= 1'b1;
        cnt  <= efvf_pkg::DIV_CNT_W'(efvf_pkg::DIV_STEPS);
        dvd  <= {nmag_in, 16'h0000};
        rem  <= '0;
        dmag <= dmag_in;
        neg  <= num[31] ^ den[31];
      end
    end else if (busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
      cnt <= cnt - 1'b1;
      if (cnt == efvf_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        // saturate the magnitude to the signed 32-bit range
        if (neg) begin
          if (dvd_next > 48'h0000_8000_0000) quo <= 32'sh80000000;
          else                               quo <= 32'(-dvd_next[31:0]);
        end else begin
          if (dvd_next > 48'h0000_7FFF_FFFF) quo <= 32'sh7FFFFFFF;
          else                               quo <= dvd_next[31:0];
        end
      end
    end
  end

endmodule

// ===== sv/efvf_front.sv =====
// Front part: accepts flow vectors, checks presence and grid, forms focus-relative offsets,
// and queues classified items for the back part. Uses efvf_pkg.
module efvf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  efvf_pkg::in_item_t            in_data,
  input  logic                          hold,
  input  logic signed [31:0]            focus_x,
  input  logic signed [31:0]            focus_y,
  input  logic [12:0]                   width_px,
  input  logic [12:0]                   height_px,
  input  logic [2:0]                    sample_shift,
  output logic                          q_valid,
  input  logic                          q_ready,
  output efvf_pkg::work_item_t          q_data
);

  efvf_pkg::work_item_t              queue [efvf_pkg::QDEPTH];
  logic [efvf_pkg::QPTR_W-1:0]       wr_ptr;
  logic [efvf_pkg::QPTR_W-1:0]       rd_ptr;
  logic [efvf_pkg::QPTR_W:0]         count;

  logic [efvf_pkg::COORD_BITS-1:0]   gmask;
  logic                              on_grid;
  logic signed [efvf_pkg::COORD_BITS:0] rel_x;
  logic signed [efvf_pkg::COORD_BITS:0] rel_y;
  efvf_pkg::work_item_t              entry;
  logic                              push;
  logic                              pop;

  assign in_ready = (count != (efvf_pkg::QPTR_W+1)'(efvf_pkg::QDEPTH)) && !hold;
  assign q_valid  = count != '0;
  assign q_data   = queue[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    gmask   = efvf_pkg::COORD_BITS'((efvf_pkg::COORD_BITS'(1) << sample_shift) - 1'b1);
    on_grid = ((in_data.pos_x & gmask) == '0) && ((in_data.pos_y & gmask) == '0);
    rel_x   = signed'({1'b0, in_data.pos_x}) - signed'({1'b0, width_px[12:1]});
    rel_y   = signed'({1'b0, in_data.pos_y}) - signed'({1'b0, height_px[12:1]});
    entry.active = in_data.present && on_grid;
    entry.pos_x  = in_data.pos_x;
    entry.pos_y  = in_data.pos_y;
    entry.flow_u = in_data.flow_u;
    entry.flow_v = in_data.flow_v;
    entry.dx = (efvf_pkg::DATA_W'(rel_x) <<< 16) - efvf_pkg::DATA_W'(focus_x);
    entry.dy = (efvf_pkg::DATA_W'(rel_y) <<< 16) - efvf_pkg::DATA_W'(focus_y);
  end

  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

// ===== sv/efvf_cordic.sv =====
// Pipelined CORDIC atan2 in vectoring mode, one register per stage, Q3.12 result.
// Quadrant pre-rotation stage, then one stage per table entry. Uses efvf_pkg.
module efvf_cordic (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [efvf_pkg::DATA_W-1:0] x_in,
  input  logic signed [efvf_pkg::DATA_W-1:0] y_in,
  output logic signed [efvf_pkg::ANGLE_W-1:0] angle
);

  localparam int N = efvf_pkg::CORDIC_STAGES;

  logic signed [efvf_pkg::DATA_W-1:0]  xs [N+1];
  logic signed [efvf_pkg::DATA_W-1:0]  ys [N+1];
  logic signed [efvf_pkg::ANGLE_W-1:0] zs [N+1];
  logic                                zero [N+1];

  // Turn left-half vectors by a quarter turn
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          xs[0] <= y_in;
          ys[0] <= -x_in;
          zs[0] <= efvf_pkg::HALF_PI;
        end else begin
          xs[0] <= -y_in;
          ys[0] <= x_in;
          zs[0] <= -efvf_pkg::HALF_PI;
        end
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic signed [efvf_pkg::ANGLE_W-1:0] A = efvf_pkg::atan_q12(k);
    always_ff @(posedge clk) begin
      if (en) begin
        zero[k+1] <= zero[k];
        if (ys[k] > 0) begin
          xs[k+1] <= xs[k] + (ys[k] >>> k);
          ys[k+1] <= ys[k] - (xs[k] >>> k);
          zs[k+1] <= zs[k] + A;
        end else begin
          xs[k+1] <= xs[k] - (ys[k] >>> k);
          ys[k+1] <= ys[k] + (xs[k] >>> k);
          zs[k+1] <= zs[k] - A;
        end
      end
    end
  end

  assign angle = zero[N] ? '0 : zs[N];

endmodule

// ===== sv/efvf_back.sv =====
// Back part: two CORDIC pipelines for expected and seen bearings, threshold compare,
// and the output register. Uses efvf_pkg and efvf_cordic.
module efvf_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  efvf_pkg::work_item_t    q_data,
  input  logic [14:0]             angle_threshold,
  output logic                    out_valid,
  input  logic                    out_ready,
  output efvf_pkg::out_item_t     out_data
);

  localparam int N = efvf_pkg::CORDIC_STAGES;

  logic                                adv;
  logic [N:0]                          vld;
  efvf_pkg::pass_t                     pass [N+1];
  logic signed [efvf_pkg::ANGLE_W-1:0] z_exp;
  logic signed [efvf_pkg::ANGLE_W-1:0] z_seen;
  logic signed [efvf_pkg::ANGLE_W:0]   diff;
  logic [efvf_pkg::ANGLE_W:0]          mag;
  logic                                keep;

  // Whole pipeline advances whenever the output slot is free or being taken
  assign adv     = !out_valid || out_ready;
  assign q_ready = adv;

  efvf_cordic u_expected (
    .clk   (clk),
    .en    (adv),
    .x_in  (q_data.dx),
    .y_in  (q_data.dy),
    .angle (z_exp)
  );

  efvf_cordic u_seen (
    .clk   (clk),
    .en    (adv),
    .x_in  (efvf_pkg::DATA_W'(q_data.flow_u)),
    .y_in  (efvf_pkg::DATA_W'(q_data.flow_v)),
    .angle (z_seen)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      pass[0] <= '{active: q_data.active, pos_x: q_data.pos_x, pos_y: q_data.pos_y,
                   flow_u: q_data.flow_u, flow_v: q_data.flow_v};
      for (int k = 1; k <= N; k++) pass[k] <= pass[k-1];
    end
  end

  always_comb begin
    diff = (efvf_pkg::ANGLE_W+1)'(z_exp) - (efvf_pkg::ANGLE_W+1)'(z_seen);
    mag  = diff[efvf_pkg::ANGLE_W] ? unsigned'(-diff) : unsigned'(diff);
    keep = pass[N].active && (mag > (efvf_pkg::ANGLE_W+1)'(angle_threshold));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[N-1:0], q_valid};
      out_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.keep  <= keep;
      out_data.out_x <= keep ? pass[N].pos_x  : '0;
      out_data.out_y <= keep ? pass[N].pos_y  : '0;
      out_data.out_u <= keep ? pass[N].flow_u : '0;
      out_data.out_v <= keep ? pass[N].flow_v : '0;
    end
  end

endmodule

// ===== sv/flow_vector_egomotion_filter.sv =====
// Top level of the egomotion flow-vector filter: configuration registers, focus dividers,
// front classifier with queue, and CORDIC back end. Uses efvf_pkg and all efvf_* modules.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   input    | in_valid / in_ready       | in_data  (present, pos_x/y, flow_u/v)
//   output   | out_valid / out_ready     | out_data (keep, out_x/y, out_u/v)
//   config   | cfg_we                    | cfg_index, cfg_data (write only)
//
// One item per cycle sustained while in_ready is high and the output is not stalled;
// an item goes through the queue slot, pre-rotation, one register per CORDIC stage, output.
// A write to odom_x, odom_y or odom_z restarts both focus dividers: in_ready stays low
// while div_start is set and while either divider is busy (one quotient bit per cycle over
// 48 bits), or for one cycle when odom_z is zero.
// rst is synchronous; it restores register defaults and clears focus to zero.
// A stall at the output freezes the CORDIC pipelines; the front queue keeps accepting
// until its four slots are full.
module flow_vector_egomotion_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  efvf_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output efvf_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [efvf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [efvf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic signed [31:0] odom_x;
  logic signed [31:0] odom_y;
  logic signed [31:0] odom_z;
  logic [12:0]        width_px;
  logic [12:0]        height_px;
  logic [14:0]        angle_threshold;
  logic [2:0]         sample_shift;

  logic               div_start;
  logic               busy_x;
  logic               busy_y;
  logic signed [31:0] focus_x;
  logic signed [31:0] focus_y;
  logic               hold;

  logic                 q_valid;
  logic                 q_ready;
  efvf_pkg::work_item_t q_data;

  // Register writes; odometry writes kick off a focus update on the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      odom_x          <= '0;
      odom_y          <= '0;
      odom_z          <= 32'sd65536;
      width_px        <= 13'd640;
      height_px       <= 13'd480;
      angle_threshold <= 15'd410;
      sample_shift    <= '0;
      div_start       <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        case (efvf_pkg::cfg_reg_t'(cfg_index))
          efvf_pkg::REG_ODOM_X: begin
            odom_x    <= cfg_data;
            div_start <= 1'b1;
          end
          efvf_pkg::REG_ODOM_Y: begin
            odom_y    <= cfg_data;
            div_start <= 1'b1;
          end
          efvf_pkg::REG_ODOM_Z: begin
            odom_z    <= cfg_data;
            div_start <= 1'b1;
          end
          efvf_pkg::REG_WIDTH_PX:     width_px        <= cfg_data[12:0];
          efvf_pkg::REG_HEIGHT_PX:    height_px       <= cfg_data[12:0];
          efvf_pkg::REG_ANGLE_THRESH: angle_threshold <= cfg_data[14:0];
          efvf_pkg::REG_SAMPLE_SHIFT: sample_shift    <= cfg_data[2:0];
          default: ;  // drop writes to unused indexes
        endcase
      end
    end
  end

  efvf_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (odom_x),
    .den   (odom_z),
    .busy  (busy_x),
    .quo   (focus_x)
  );

  efvf_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (odom_y),
    .den   (odom_z),
    .busy  (busy_y),
    .quo   (focus_y)
  );

  // Hold input acceptance until the focus is settled
  assign hold = div_start || busy_x || busy_y;

  efvf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .hold         (hold),
    .focus_x      (focus_x),
    .focus_y      (focus_y),
    .width_px     (width_px),
    .height_px    (height_px),
    .sample_shift (sample_shift),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data)
  );

  efvf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_data          (q_data),
    .angle_threshold (angle_threshold),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

endmodule
